@@ hdl/lom_pkg.sv @@
// Package for the limit order matcher: transaction types, kinds, engine states.
// No dependencies.
package lom_pkg;

	typedef enum logic [2:0] {
		KIND_TRADE     = 3'd0,
		KIND_RESTED    = 3'd1,
		KIND_NONE      = 3'd2,
		KIND_CANCELLED = 3'd3,
		KIND_NOT_FOUND = 3'd4,
		KIND_REJECTED  = 3'd5
	} kind_t;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;
	localparam logic SIDE_BUY   = 1'b0;

	typedef struct packed {
		logic        req_type;
		logic        side;
		logic [15:0] price;
		logic [31:0] quantity;
		logic [31:0] cancel_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] buy_id;
		logic [31:0] sell_id;
		logic [15:0] trade_price;
		logic [31:0] trade_qty;
		logic [31:0] ref_id;
		logic [31:0] left_qty;
		logic        last;
	} res_t;

	// classified command from front to back
	typedef struct packed {
		logic        cancel;
		logic        side;
		logic [15:0] price;
		logic [31:0] qty;
		logic [31:0] id;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_FILL,
		ST_DONE
	} eng_state_t;

endpackage

@@ hdl/lom_front.sv @@
// Front end: accepts requests, assigns order ids, pushes commands into a queue.
// Depends on lom_pkg.
module lom_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lom_pkg::req_t  req,
	output logic           busy,
	input  logic           pop,
	output logic           cmd_valid,
	output lom_pkg::cmd_t  cmd,
	input  logic           engine_idle
);
	lom_pkg::cmd_t q_q [2];
	logic [1:0]    cnt_q;
	logic          rd_q, wr_q;
	logic [31:0]   next_id_q;
	logic          push;
	lom_pkg::cmd_t c;

	// one request in flight at a time: queue decouples the handshake from the engine
	assign busy      = (cnt_q != 2'd0) || !engine_idle;
	assign push      = start && !busy;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rd_q];

	always_comb begin
		c.cancel = req.req_type == lom_pkg::REQ_CANCEL;
		c.side   = req.side;
		c.price  = req.price;
		c.qty    = req.quantity;
		c.id     = c.cancel ? req.cancel_id : next_id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_q      <= 1'b0;
			wr_q      <= 1'b0;
			next_id_q <= 32'd1;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
				if (!c.cancel) next_id_q <= next_id_q + 32'd1;
			end
			if (pop && cnt_q != 2'd0) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop && cnt_q != 2'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= c;
	end
endmodule

@@ hdl/lom_engine.sv @@
// Back end: order table, best-order scan, fills, resting and cancels.
// Depends on lom_pkg.
module lom_engine #(
	parameter int MAX_ORDERS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  lom_pkg::cmd_t cmd,
	output logic          pop,
	output logic          idle,
	output logic          done,
	output lom_pkg::res_t result
);
	localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

	logic [MAX_ORDERS-1:0] valid_q;
	logic                  side_q [MAX_ORDERS];
	logic [15:0]           price_m [MAX_ORDERS];
	logic [31:0]           qty_m [MAX_ORDERS];
	logic [31:0]           id_m [MAX_ORDERS];

	lom_pkg::eng_state_t state_q, state_d;
	lom_pkg::cmd_t       cur_q;
	logic [AW:0]         idx_q;
	logic [AW-1:0]       best_q, free_q;
	logic [15:0]         bprice_q;
	logic [31:0]         bid_q;
	logic [15:0]         rd_price_q;
	logic [31:0]         rd_qty_q, rd_id_q;
	logic                rd_side_q;
	logic [AW-1:0]       rdx_q;
	logic                rdv_q;
	logic                found_sel_q, free_sel_q;

	logic [AW-1:0] ia;
	logic          sel_valid, crosses, better, scan_end;
	logic [31:0]   fill;

	assign ia        = idx_q[AW-1:0];
	assign scan_end  = idx_q == (AW+1)'(MAX_ORDERS);
	assign idle      = state_q == lom_pkg::ST_IDLE;
	assign pop       = idle && cmd_valid;
	assign sel_valid = valid_q[rdx_q];

	always_comb begin
		crosses = sel_valid && (rd_side_q != cur_q.side) &&
			(cur_q.side == lom_pkg::SIDE_BUY ? rd_price_q <= cur_q.price
			                                : rd_price_q >= cur_q.price);
		better  = !found_sel_q ||
			(cur_q.side == lom_pkg::SIDE_BUY ? rd_price_q < bprice_q
			                                : rd_price_q > bprice_q) ||
			(rd_price_q == bprice_q && rd_id_q < bid_q);
		fill    = (cur_q.qty < rd_qty_q) ? cur_q.qty : rd_qty_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lom_pkg::ST_IDLE: if (cmd_valid) state_d = lom_pkg::ST_SCAN;
			lom_pkg::ST_SCAN: if (scan_end) state_d = lom_pkg::ST_READ;
			lom_pkg::ST_READ: begin
				if (cur_q.cancel || cur_q.qty == 32'd0 || !found_sel_q)
					state_d = lom_pkg::ST_DONE;
				else state_d = lom_pkg::ST_FILL;
			end
			lom_pkg::ST_FILL: state_d = lom_pkg::ST_SCAN;
			lom_pkg::ST_DONE: state_d = lom_pkg::ST_IDLE;
			default: state_d = lom_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		result = '0;
		done   = 1'b0;
		unique case (state_q)
			lom_pkg::ST_FILL: begin
				done               = 1'b1;
				result.kind        = lom_pkg::KIND_TRADE;
				result.buy_id      = cur_q.side == lom_pkg::SIDE_BUY ? cur_q.id : rd_id_q;
				result.sell_id     = cur_q.side == lom_pkg::SIDE_BUY ? rd_id_q : cur_q.id;
				result.trade_price = rd_price_q;
				result.trade_qty   = fill;
			end
			lom_pkg::ST_DONE: begin
				done          = 1'b1;
				result.last   = 1'b1;
				result.ref_id = cur_q.id;
				if (cur_q.cancel) begin
					result.kind = found_sel_q ? lom_pkg::KIND_CANCELLED : lom_pkg::KIND_NOT_FOUND;
				end else if (cur_q.qty == 32'd0) begin
					result.kind = lom_pkg::KIND_NONE;
				end else if (free_sel_q) begin
					result.kind     = lom_pkg::KIND_RESTED;
					result.left_qty = cur_q.qty;
				end else begin
					result.kind     = lom_pkg::KIND_REJECTED;
					result.left_qty = cur_q.qty;
				end
			end
			default: ;
		endcase
	end

	// scan pipeline: read one slot per cycle, compare the previous read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lom_pkg::ST_IDLE;
			valid_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lom_pkg::ST_IDLE: idx_q <= '0;
				lom_pkg::ST_SCAN: if (!scan_end) idx_q <= idx_q + (AW+1)'(1);
				lom_pkg::ST_READ: ;
				lom_pkg::ST_FILL: begin
					idx_q <= '0;
					if (rd_qty_q == fill) valid_q[best_q] <= 1'b0;
				end
				lom_pkg::ST_DONE: begin
					if (cur_q.cancel && found_sel_q) valid_q[best_q] <= 1'b0;
					if (!cur_q.cancel && cur_q.qty != 32'd0 && free_sel_q)
						valid_q[free_q] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lom_pkg::ST_IDLE && cmd_valid) cur_q <= cmd;
		if (state_q == lom_pkg::ST_FILL) cur_q.qty <= cur_q.qty - fill;
		rdv_q <= state_q == lom_pkg::ST_SCAN && !scan_end;
		rdx_q <= ia;
		if (state_q == lom_pkg::ST_SCAN && !scan_end) begin
			rd_side_q  <= side_q[ia];
			rd_price_q <= price_m[ia];
			rd_qty_q   <= qty_m[ia];
			rd_id_q    <= id_m[ia];
		end
		if (state_q == lom_pkg::ST_READ) begin
			rd_side_q  <= side_q[best_q];
			rd_price_q <= price_m[best_q];
			rd_qty_q   <= qty_m[best_q];
			rd_id_q    <= id_m[best_q];
		end
		if (state_q == lom_pkg::ST_FILL && rd_qty_q != fill) qty_m[best_q] <= rd_qty_q - fill;
		if (state_q == lom_pkg::ST_DONE && !cur_q.cancel && cur_q.qty != 32'd0 && free_sel_q) begin
			side_q[free_q]  <= cur_q.side;
			price_m[free_q] <= cur_q.price;
			qty_m[free_q]   <= cur_q.qty;
			id_m[free_q]    <= cur_q.id;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lom_pkg::ST_IDLE || state_q == lom_pkg::ST_FILL) begin
			bprice_q <= '0;
			bid_q    <= '0;
		end
		if (rdv_q) begin
			if (cur_q.cancel) begin
				if (!found_sel_q && sel_valid && rd_id_q == cur_q.id) best_q <= rdx_q;
			end else if (crosses && better) begin
				best_q   <= rdx_q;
				bprice_q <= rd_price_q;
				bid_q    <= rd_id_q;
			end
			if (!sel_valid && !free_sel_q) free_q <= rdx_q;
		end
	end

	// selection flags live alongside the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_sel_q <= 1'b0;
			free_sel_q  <= 1'b0;
		end else if (state_q == lom_pkg::ST_IDLE || state_q == lom_pkg::ST_FILL) begin
			found_sel_q <= 1'b0;
			free_sel_q  <= 1'b0;
		end else if (rdv_q) begin
			if (cur_q.cancel) begin
				if (sel_valid && rd_id_q == cur_q.id) found_sel_q <= 1'b1;
			end else if (crosses) begin
				found_sel_q <= 1'b1;
			end
			if (!sel_valid) free_sel_q <= 1'b1;
		end
	end
endmodule

@@ hdl/limit_order_matcher.sv @@
// Top level of the limit order matcher: front end, command queue, matching engine.
// Depends on lom_pkg, lom_front, lom_engine.
//
// channel   handshake               payload
// request   start && !busy          req    (lom_pkg::req_t)
// result    done (one cycle)        result (lom_pkg::res_t)
//
// One request at a time. Each pass scans the table one slot a cycle and then reads
// the best slot; a trade leaves in the last cycle of each filling pass, the status
// in the last cycle of the final pass. An add with F fills (a cancel: F = 0) takes
// F + 1 passes.
// Reset clears the valid bits and sets the next id to one. Results cannot be stalled.
module limit_order_matcher #(
	parameter int MAX_ORDERS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lom_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output lom_pkg::res_t result
);
	logic          cmd_valid, pop, engine_idle;
	lom_pkg::cmd_t cmd;

	lom_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.pop(pop), .cmd_valid(cmd_valid), .cmd(cmd), .engine_idle(engine_idle)
	);

	lom_engine #(.MAX_ORDERS(MAX_ORDERS)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop),
		.idle(engine_idle), .done(done), .result(result)
	);
endmodule

@@ hdl/lom_checker.sv @@
// Port-level checker for the limit order matcher, bound to the top level.
// Depends on lom_pkg and limit_order_matcher.
module lom_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input lom_pkg::res_t result
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("not busy after accept");
	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kind == lom_pkg::KIND_TRADE |-> !result.last)
		else $error("trade marked last");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.kind != lom_pkg::KIND_TRADE |-> result.last)
		else $error("status not last");
	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");
endmodule

bind limit_order_matcher lom_checker u_lom_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .result(result)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for limit_order_matcher: directed and random add/cancel transactions,
// predicted by an in-bench order book model and checked field by field. Depends on lom_pkg.
module tb;
	localparam int DEPTH = 32;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic start;
	lom_pkg::req_t req;
	logic busy;
	logic done;
	lom_pkg::res_t result;

	limit_order_matcher #(.MAX_ORDERS(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic        bk_valid [DEPTH];
	logic        bk_side [DEPTH];
	logic [15:0] bk_price [DEPTH];
	logic [31:0] bk_qty [DEPTH];
	logic [31:0] bk_id [DEPTH];
	logic [31:0] bk_next_id;

	lom_pkg::req_t pending_reqs [$];
	lom_pkg::res_t expected_results [$];
	int fail_count = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;
	logic took_q = 1'b0;

	function automatic void add_expected(lom_pkg::res_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic void queue_req(lom_pkg::req_t t);
		pending_reqs = {pending_reqs, t};
	endfunction

	function automatic lom_pkg::res_t status(lom_pkg::kind_t k, logic [31:0] rid,
			logic [31:0] left);
		lom_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.ref_id = rid;
		r.left_qty = left;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_request(input lom_pkg::req_t t);
		int best;
		logic [31:0] oid;
		logic [31:0] rem;
		logic [31:0] fill;
		lom_pkg::res_t r;
		bit ok;
		if (t.req_type == lom_pkg::REQ_CANCEL) begin
			for (int i = 0; i < DEPTH; i++)
				if (bk_valid[i] && bk_id[i] == t.cancel_id) begin
					bk_valid[i] = 1'b0;
					add_expected(status(lom_pkg::KIND_CANCELLED, t.cancel_id, 32'd0));
					return;
				end
			add_expected(status(lom_pkg::KIND_NOT_FOUND, t.cancel_id, 32'd0));
			return;
		end
		oid = bk_next_id;
		bk_next_id = bk_next_id + 32'd1;
		rem = t.quantity;
		while (rem != 32'd0) begin
			best = -1;
			for (int i = 0; i < DEPTH; i++) begin
				if (!bk_valid[i] || bk_side[i] == t.side) continue;
				if (t.side == lom_pkg::SIDE_BUY) begin
					if (bk_price[i] > t.price) continue;
					ok = best < 0 || bk_price[i] < bk_price[best];
				end else begin
					if (bk_price[i] < t.price) continue;
					ok = best < 0 || bk_price[i] > bk_price[best];
				end
				if (ok || (bk_price[i] == bk_price[best] && bk_id[i] < bk_id[best]))
					best = i;
			end
			if (best < 0) break;
			fill = rem < bk_qty[best] ? rem : bk_qty[best];
			r = '0;
			r.kind = lom_pkg::KIND_TRADE;
			r.buy_id = t.side == lom_pkg::SIDE_BUY ? oid : bk_id[best];
			r.sell_id = t.side == lom_pkg::SIDE_BUY ? bk_id[best] : oid;
			r.trade_price = bk_price[best];
			r.trade_qty = fill;
			add_expected(r);
			rem -= fill;
			bk_qty[best] -= fill;
			if (bk_qty[best] == 32'd0) bk_valid[best] = 1'b0;
		end
		if (rem == 32'd0) begin
			add_expected(status(lom_pkg::KIND_NONE, oid, 32'd0));
			return;
		end
		for (int i = 0; i < DEPTH; i++)
			if (!bk_valid[i]) begin
				bk_valid[i] = 1'b1;
				bk_side[i] = t.side;
				bk_price[i] = t.price;
				bk_qty[i] = rem;
				bk_id[i] = oid;
				add_expected(status(lom_pkg::KIND_RESTED, oid, rem));
				return;
			end
		add_expected(status(lom_pkg::KIND_REJECTED, oid, rem));
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!start || took_q)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		took_q <= arst_n && start && !busy;
		if (arst_n) begin
			quiet_cycles <= ((start && !busy) || done) ? 0 : quiet_cycles + 1;
			if (start && !busy)
				predict_request(req);
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result kind %0d", result.kind);
					fail_count++;
				end else begin
					lom_pkg::res_t e;
					e = expected_results.pop_front();
					if (e.kind !== result.kind) begin
						$error("kind exp %0d got %0d", e.kind, result.kind); fail_count++; end
					if (e.buy_id !== result.buy_id) begin
						$error("buy_id exp %0d got %0d", e.buy_id, result.buy_id); fail_count++; end
					if (e.sell_id !== result.sell_id) begin
						$error("sell_id exp %0d got %0d", e.sell_id, result.sell_id); fail_count++; end
					if (e.trade_price !== result.trade_price) begin
						$error("trade_price exp %0d got %0d", e.trade_price, result.trade_price);
						fail_count++; end
					if (e.trade_qty !== result.trade_qty) begin
						$error("trade_qty exp %0d got %0d", e.trade_qty, result.trade_qty);
						fail_count++; end
					if (e.ref_id !== result.ref_id) begin
						$error("ref_id exp %0d got %0d", e.ref_id, result.ref_id); fail_count++; end
					if (e.left_qty !== result.left_qty) begin
						$error("left_qty exp %0d got %0d", e.left_qty, result.left_qty);
						fail_count++; end
					if (e.last !== result.last) begin
						$error("last exp %0d got %0d", e.last, result.last); fail_count++; end
				end
			end
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic lom_pkg::req_t mk_add(logic s, logic [15:0] p, logic [31:0] q);
		lom_pkg::req_t t;
		t.req_type = lom_pkg::REQ_ADD;
		t.side = s;
		t.price = p;
		t.quantity = q;
		t.cancel_id = $urandom;
		return t;
	endfunction

	function automatic lom_pkg::req_t mk_cancel(logic [31:0] id);
		lom_pkg::req_t t;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		t = raw[$bits(lom_pkg::req_t)-1:0];
		t.req_type = lom_pkg::REQ_CANCEL;
		t.cancel_id = id;
		return t;
	endfunction

	function automatic lom_pkg::req_t rand_req(int issued);
		logic [31:0] q;
		int sel;
		sel = $urandom_range(99);
		if (sel < 20)
			return mk_cancel(sel < 15 ? $urandom_range(issued + 2) : $urandom);
		case ($urandom_range(3))
			0: q = $urandom;
			1: q = 32'd0;
			default: q = $urandom_range(50, 1);
		endcase
		return mk_add(1'($urandom_range(1)),
			sel < 90 ? 16'($urandom_range(1010, 990)) : 16'($urandom), q);
	endfunction

	initial begin
		int issued;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		clk = 1'b0;
		for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
		bk_next_id = 32'd1;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_req(mk_add(1'b0, 16'd0, 32'd0));
		queue_req(mk_add(1'b1, 16'hFFFF, 32'hFFFF_FFFF));
		queue_req(mk_add(1'b0, 16'hFFFF, 32'd10));
		queue_req(mk_add(1'b1, 16'd100, 32'd5));
		queue_req(mk_add(1'b1, 16'd100, 32'd7));
		queue_req(mk_add(1'b1, 16'd90, 32'd3));
		queue_req(mk_add(1'b0, 16'd100, 32'd12));
		queue_req(mk_cancel(32'd5));
		queue_req(mk_cancel(32'd5));
		queue_req(mk_cancel(32'hFFFF_FFFF));
		queue_req(mk_add(1'b0, 16'd0, 32'd1));
		queue_req(mk_add(1'b1, 16'd0, 32'd4));
		for (int i = 0; i < 34; i++)
			queue_req(mk_add(1'b0, 16'd50, 32'd1));
		queue_req(mk_add(1'b1, 16'd0, 32'd40));
		issued = 48;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 1 ? 52 : (ph == 3 ? 28 : 0);
			for (int i = 0; i < 26; i++) begin
				queue_req(rand_req(issued));
				issued++;
			end
			wait (pending_reqs.size() == 0 && !start);
		end
		wait (expected_results.size() == 0);
		repeat (4 * DEPTH + 20) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

@@ files.f @@
hdl/lom_pkg.sv
hdl/lom_front.sv
hdl/lom_engine.sv
hdl/limit_order_matcher.sv
hdl/lom_checker.sv
sim/tb.sv
